// ----- design/skt_pkg.sv -----
`timescale 1ns / 1ps

package skt_pkg;

	// Field widths of the request and response
	localparam int CMD_W = 3;
	localparam int KEY_W = 32;
	localparam int POS_W = 4;
	localparam int CNT_W = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FIND      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

	// Capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic             status;
		logic             found;
		logic [CNT_W-1:0] found_index;
		logic [KEY_W-1:0] found_key;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
		logic             is_full;
	} rsp_t;

	// Update applied by every cell in the execute cycle
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INSERT,
		ACT_DEL_KEY,
		ACT_DEL_POS
	} act_e;

	// Broadcast control from the sequencer to the cells
	typedef struct packed {
		logic             load;
		act_e             act;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} cell_ctl_t;

	// Per-cell compare results
	typedef struct packed {
		logic lt;
		logic eq;
		logic below;
		logic at_lb;
	} cell_flags_t;

endpackage

// ----- design/skt_cell.sv -----
`timescale 1ns / 1ps

module skt_cell #(
	parameter int IDX = 0,
	parameter int KW  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  skt_pkg::cell_ctl_t ctl,
	input  logic [KW-1:0]      cmp_key,
	input  logic [KW-1:0]      new_key,
	input  logic [KW-1:0]      left_key,
	input  logic               left_lt,
	input  logic               left_below,
	input  logic [KW-1:0]      right_key,
	input  logic               right_below,
	output logic [KW-1:0]      key,
	output skt_pkg::cell_flags_t flags
);
	import skt_pkg::*;

	logic [KW-1:0] key_q;
	logic          lt_s1;
	logic          eq_s1;
	logic          below;
	logic          at_lb;
	logic          from_pos;

	assign below    = IDX < int'(ctl.count);
	assign at_lb    = !lt_s1 && left_lt && left_below;
	assign from_pos = IDX >= int'(ctl.pos);

	// Compare against the incoming key when a request is taken
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lt_s1 <= below && (key_q < cmp_key);
			eq_s1 <= key_q == cmp_key;
		end
	end

	// Shift, insert or hold the stored key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else begin
			case (ctl.act)
				ACT_INSERT: begin
					if (at_lb) begin
						key_q <= new_key;
					end else if (!lt_s1 && !left_lt && left_below) begin
						key_q <= left_key;
					end
				end
				ACT_DEL_KEY: begin
					if (!lt_s1 && right_below) begin
						key_q <= right_key;
					end
				end
				ACT_DEL_POS: begin
					if (from_pos && right_below) begin
						key_q <= right_key;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign key         = key_q;
	assign flags.lt    = lt_s1;
	assign flags.eq    = eq_s1;
	assign flags.below = below;
	assign flags.at_lb = at_lb;

endmodule

// ----- design/sorted_key_table.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// request   | in        | req_valid/req_ready  | req (command, key, position)
// response  | out       | rsp_valid/rsp_ready  | rsp (status, found, index, key, count, flags)
// capacity  | in        | cfg_we               | cfg_data
//
// Keys are compared in every cell on the accept edge; the result is then selected
// and the row of cells shifts on the edge at which the request executes.
// A new request is taken only once the previous one has executed.
// A pending response that is not taken stalls execution of the next request.
// Reset clears all stored keys, the count, and sets the capacity to 16.
module sorted_key_table #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  skt_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output skt_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [skt_pkg::CNT_W-1:0] cfg_data
);
	import skt_pkg::*;

	// Stored key width and number of cells that can ever hold an entry
	localparam int SW     = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
	localparam int CNT_MX = (1 << CNT_W) - 1;
	localparam int N      = (DEPTH < CNT_MX) ? DEPTH : CNT_MX;
	localparam logic [CNT_W-1:0] N_CAP = CNT_W'(N);

	req_t             req_q;
	logic             busy_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             exec;
	logic [CNT_W-1:0] eff_cap;
	cell_ctl_t        ctl;
	logic [SW-1:0]    in_key;
	logic [SW-1:0]    req_key;

	logic [SW-1:0]    cell_key [N];
	cell_flags_t      cell_flg [N];

	logic             lb_found;
	logic             lb_eq;
	logic [CNT_W-1:0] lb_idx;
	logic [SW-1:0]    lb_key;
	logic [SW-1:0]    pos_key;

	act_e             act;
	rsp_t             rsp_d;
	logic [CNT_W-1:0] count_d;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;
	assign exec      = busy_q && (!rsp_valid_q || rsp_ready);
	assign eff_cap   = (cap_q > N_CAP) ? N_CAP : cap_q;
	assign in_key    = req.key[SW-1:0];
	assign req_key   = req_q.key[SW-1:0];

	assign ctl.load  = accept;
	assign ctl.act   = exec ? act : ACT_HOLD;
	assign ctl.pos   = req_q.position;
	assign ctl.count = count_q;

	// Row of cells with neighbour links
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [SW-1:0] l_key;
		logic          l_lt;
		logic          l_below;
		logic [SW-1:0] r_key;
		logic          r_below;

		if (i == 0) begin : g_first
			assign l_key   = '0;
			assign l_lt    = 1'b1;
			assign l_below = 1'b1;
		end else begin : g_inner
			assign l_key   = cell_key[i-1];
			assign l_lt    = cell_flg[i-1].lt;
			assign l_below = cell_flg[i-1].below;
		end

		if (i == N - 1) begin : g_last
			assign r_key   = '0;
			assign r_below = 1'b0;
		end else begin : g_mid
			assign r_key   = cell_key[i+1];
			assign r_below = cell_flg[i+1].below;
		end

		skt_cell #(
			.IDX (i),
			.KW  (SW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cmp_key     (in_key),
			.new_key     (req_key),
			.left_key    (l_key),
			.left_lt     (l_lt),
			.left_below  (l_below),
			.right_key   (r_key),
			.right_below (r_below),
			.key         (cell_key[i]),
			.flags       (cell_flg[i])
		);
	end

	// Gather the lower-bound entry and the entry at the requested position
	always_comb begin
		lb_found = 1'b0;
		lb_eq    = 1'b0;
		lb_idx   = '0;
		lb_key   = '0;
		pos_key  = '0;
		for (int i = 0; i < N; i++) begin
			if (cell_flg[i].at_lb) begin
				lb_idx = lb_idx | CNT_W'(i);
			end
			if (cell_flg[i].at_lb && cell_flg[i].below) begin
				lb_found = 1'b1;
				lb_eq    = lb_eq | cell_flg[i].eq;
				lb_key   = lb_key | cell_key[i];
			end
			if (i == int'(req_q.position)) begin
				pos_key = pos_key | cell_key[i];
			end
		end
	end

	// Decode the command into a cell update and a response
	always_comb begin
		act               = ACT_HOLD;
		count_d           = count_q;
		rsp_d.status      = 1'b0;
		rsp_d.found       = 1'b0;
		rsp_d.found_index = '0;
		rsp_d.found_key   = '0;
		unique case (req_q.command)
			CMD_INSERT: begin
				if (count_q >= eff_cap) begin
					rsp_d.status = 1'b1;
				end else begin
					act               = ACT_INSERT;
					count_d           = count_q + 1'b1;
					rsp_d.found_index = lb_idx;
					rsp_d.found_key   = KEY_W'(req_key);
				end
			end
			CMD_FIND: begin
				if (lb_found) begin
					rsp_d.found       = 1'b1;
					rsp_d.found_index = lb_idx;
					rsp_d.found_key   = KEY_W'(lb_key);
				end
			end
			CMD_REMOVE: begin
				if (count_q == '0) begin
					rsp_d.status = 1'b1;
				end else if (lb_found && lb_eq) begin
					act               = ACT_DEL_KEY;
					count_d           = count_q - 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.found_index = lb_idx;
					rsp_d.found_key   = KEY_W'(lb_key);
				end
			end
			CMD_REMOVE_AT: begin
				if (CNT_W'(req_q.position) >= count_q) begin
					rsp_d.status = 1'b1;
				end else begin
					act               = ACT_DEL_POS;
					count_d           = count_q - 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.found_index = CNT_W'(req_q.position);
					rsp_d.found_key   = KEY_W'(pos_key);
				end
			end
			CMD_GET: begin
				if (CNT_W'(req_q.position) >= eff_cap) begin
					rsp_d.status = 1'b1;
				end else begin
					rsp_d.found_index = CNT_W'(req_q.position);
					rsp_d.found_key   = KEY_W'(pos_key);
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = count_d;
		rsp_d.is_empty    = count_d == '0;
		rsp_d.is_full     = count_d >= eff_cap;
	end

	// Hold the request while it executes
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// Load the response register when a request executes
	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

	// Track busy, response valid, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- dv/tb_sorted_key_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int TBL_DEPTH     = 16;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 110;

	// Command codes the block does not decode
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_data;

	// Mirror of the table contents, count and capacity
	logic [KEY_W-1:0] tbl_keys [TBL_DEPTH];
	int               tbl_count;
	logic [CNT_W-1:0] tbl_cap;

	// Responses still owed by the block, oldest first
	rsp_t             pending_rsp [$];
	rsp_t             due_rsp;

	logic [KEY_W-1:0] key_pool [8];
	int               send_idle_pct;
	int               rsp_stall_pct;
	int               mismatches;
	int               n_sent;
	int               n_checked;
	int               n_refused;
	int               n_located;

	sorted_key_table #(
		.DEPTH     (TBL_DEPTH),
		.KEY_WIDTH (KEY_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Give up on a hung run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Stall the response side at random
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	function automatic int effective_cap();
		return (tbl_cap > TBL_DEPTH) ? TBL_DEPTH : int'(tbl_cap);
	endfunction

	// Close the gap left by a removed entry; the top slot keeps its old key
	function automatic void drop_entry(input int idx);
		for (int i = idx; i + 1 < tbl_count; i++)
			tbl_keys[i] = tbl_keys[i + 1];
		tbl_count--;
	endfunction

	// Apply one request to the mirror and return the response it must give
	function automatic rsp_t predict_rsp(input req_t r);
		rsp_t o;
		int   lb;
		int   cap_eff;
		int   pos;
		o       = '0;
		cap_eff = effective_cap();
		pos     = int'(r.position);
		lb      = tbl_count;
		for (int i = tbl_count - 1; i >= 0; i--)
			if (tbl_keys[i] >= r.key)
				lb = i;
		case (r.command)
			CMD_INSERT: begin
				if (tbl_count >= cap_eff) begin
					o.status = 1'b1;
					n_refused++;
				end else begin
					for (int i = tbl_count; i > lb; i--)
						tbl_keys[i] = tbl_keys[i - 1];
					tbl_keys[lb] = r.key;
					tbl_count++;
					o.found_index = lb[CNT_W-1:0];
					o.found_key   = r.key;
				end
			end
			CMD_FIND: begin
				if (lb < tbl_count) begin
					o.found       = 1'b1;
					o.found_index = lb[CNT_W-1:0];
					o.found_key   = tbl_keys[lb];
					n_located++;
				end
			end
			CMD_REMOVE: begin
				if (tbl_count == 0) begin
					o.status = 1'b1;
				end else if (lb < tbl_count && tbl_keys[lb] == r.key) begin
					o.found       = 1'b1;
					o.found_index = lb[CNT_W-1:0];
					o.found_key   = tbl_keys[lb];
					drop_entry(lb);
					n_located++;
				end
			end
			CMD_REMOVE_AT: begin
				if (pos >= tbl_count) begin
					o.status = 1'b1;
				end else begin
					o.found       = 1'b1;
					o.found_index = pos[CNT_W-1:0];
					o.found_key   = tbl_keys[pos];
					drop_entry(pos);
					n_located++;
				end
			end
			CMD_GET: begin
				// range is the capacity, so slots above the count read stale keys
				if (pos >= cap_eff) begin
					o.status = 1'b1;
				end else begin
					o.found_index = pos[CNT_W-1:0];
					o.found_key   = tbl_keys[pos];
				end
			end
			CMD_CLEAR: begin
				tbl_count = 0;
			end
			default: begin
			end
		endcase
		o.entry_count = tbl_count[CNT_W-1:0];
		o.is_empty    = (tbl_count == 0);
		o.is_full     = (tbl_count >= cap_eff);
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
	                                    input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every accepted response with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t ns: response with none expected, actual %0h", $time, rsp);
				mismatches++;
			end else begin
				due_rsp = pending_rsp.pop_front();
				check_field("status", KEY_W'(due_rsp.status), KEY_W'(rsp.status));
				check_field("found", KEY_W'(due_rsp.found), KEY_W'(rsp.found));
				check_field("found_index", KEY_W'(due_rsp.found_index),
				            KEY_W'(rsp.found_index));
				check_field("found_key", due_rsp.found_key, rsp.found_key);
				check_field("entry_count", KEY_W'(due_rsp.entry_count),
				            KEY_W'(rsp.entry_count));
				check_field("is_empty", KEY_W'(due_rsp.is_empty), KEY_W'(rsp.is_empty));
				check_field("is_full", KEY_W'(due_rsp.is_full), KEY_W'(rsp.is_full));
				n_checked++;
			end
		end
	end

	// Offer one request, idling first at random, and hold it until taken
	task automatic send_req(input req_t r);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		pending_rsp.push_back(predict_rsp(r));
		n_sent++;
	endtask

	// Drop valid and let every owed response drain
	task automatic wait_idle();
		req_valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending_rsp.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_we   <= 1'b1;
		@(posedge clk);
		tbl_cap = value;
		cfg_we  <= 1'b0;
	endtask

	function automatic req_t make_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
	                                  input logic [POS_W-1:0] pos);
		req_t r;
		r.command  = cmd;
		r.key      = key;
		r.position = pos;
		return r;
	endfunction

	// Build a request steered by the mirror so lookups and removals often hit
	function automatic req_t random_req();
		req_t r;
		int   roll;
		int   key_roll;
		roll     = $urandom_range(99);
		key_roll = $urandom_range(99);
		if (key_roll < 45 || (key_roll < 60 && tbl_count == 0))
			r.key = key_pool[$urandom_range(7)];
		else if (key_roll < 60)
			r.key = tbl_keys[$urandom_range(tbl_count - 1, 0)];
		else if (key_roll < 75)
			r.key = $urandom_range(15);
		else
			r.key = $urandom;
		if (tbl_count > 0 && $urandom_range(99) < 60)
			r.position = POS_W'($urandom_range(tbl_count - 1, 0));
		else
			r.position = POS_W'($urandom_range(15));
		if (tbl_count >= effective_cap() && $urandom_range(9) == 0)
			r.command = CMD_CLEAR;
		else if (roll < 45)
			r.command = CMD_INSERT;
		else if (roll < 62)
			r.command = CMD_FIND;
		else if (roll < 75)
			r.command = CMD_REMOVE;
		else if (roll < 83)
			r.command = CMD_REMOVE_AT;
		else if (roll < 95)
			r.command = CMD_GET;
		else if (roll < 98)
			r.command = CMD_CLEAR;
		else
			r.command = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
		return r;
	endfunction

	// Empty table, extreme keys, duplicates, misses and stale slots
	task automatic test_directed_cases();
		send_req(make_req(CMD_GET, 32'h0, 4'd0));
		send_req(make_req(CMD_GET, 32'h0, 4'd15));
		send_req(make_req(CMD_FIND, 32'h0, 4'd0));
		send_req(make_req(CMD_REMOVE, 32'h7, 4'd0));
		send_req(make_req(CMD_REMOVE_AT, 32'h0, 4'd0));
		send_req(make_req(CMD_INSERT, 32'hFFFF_FFFF, 4'd0));
		send_req(make_req(CMD_INSERT, 32'h0, 4'd0));
		send_req(make_req(CMD_INSERT, 32'h5, 4'd0));
		send_req(make_req(CMD_INSERT, 32'h5, 4'd0));
		send_req(make_req(CMD_INSERT, 32'h8000_0000, 4'd0));
		send_req(make_req(CMD_FIND, 32'h5, 4'd0));
		send_req(make_req(CMD_FIND, 32'h6, 4'd0));
		send_req(make_req(CMD_REMOVE, 32'h6, 4'd0));
		send_req(make_req(CMD_REMOVE, 32'h5, 4'd0));
		send_req(make_req(CMD_REMOVE_AT, 32'h0, 4'd15));
		send_req(make_req(CMD_REMOVE_AT, 32'h0, 4'd3));
		send_req(make_req(CMD_FIND, 32'hFFFF_FFFF, 4'd0));
		send_req(make_req(CMD_GET, 32'h0, 4'd4));
		send_req(make_req(CMD_GET, 32'h0, 4'd2));
		send_req(make_req(CMD_SPARE_6, 32'hA5A5_5A5A, 4'd9));
		send_req(make_req(CMD_SPARE_7, 32'h5A5A_A5A5, 4'd6));
		send_req(make_req(CMD_CLEAR, 32'h0, 4'd0));
		send_req(make_req(CMD_GET, 32'h0, 4'd1));
		send_req(make_req(CMD_FIND, 32'h0, 4'd0));
	endtask

	// Smallest capacity, capacity below the count, and an oversize value
	task automatic test_capacity_limits();
		write_capacity(5'd1);
		send_req(make_req(CMD_INSERT, $urandom, 4'd0));
		send_req(make_req(CMD_INSERT, $urandom, 4'd0));
		write_capacity(5'd0);
		send_req(make_req(CMD_INSERT, 32'h1, 4'd0));
		send_req(make_req(CMD_GET, 32'h0, 4'd0));
		write_capacity(5'd31);
		send_req(make_req(CMD_GET, 32'h0, 4'd15));
		send_req(make_req(CMD_INSERT, 32'h0, 4'd0));
		write_capacity(5'd16);
	endtask

	// Random traffic in phases of capacity and handshake idling
	task automatic test_random_traffic();
		logic [CNT_W-1:0] caps [8];
		caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd16, 5'd9, 5'd2};
		caps[6] = CNT_W'($urandom_range(15, 2));
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 17;
					rsp_stall_pct = 17;
				end
			endcase
			// pool of keys for this phase, edges of the key range included
			foreach (key_pool[k])
				key_pool[k] = $urandom;
			key_pool[0] = '0;
			key_pool[7] = '1;
			key_pool[2] = key_pool[1] + 1;
			repeat (PHASE_ITEMS) send_req(random_req());
		end
		send_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		cfg_we        = 1'b0;
		cfg_data      = CAP_RESET;
		tbl_count     = 0;
		tbl_cap       = CAP_RESET;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		mismatches    = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_refused     = 0;
		n_located     = 0;
		foreach (tbl_keys[i])
			tbl_keys[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_capacity_limits();
		test_random_traffic();

		wait_idle();
		if (pending_rsp.size() != 0) begin
			$display("%0t ns: %0d responses never arrived", $time, pending_rsp.size());
			mismatches += pending_rsp.size();
		end
		$display("Checked %0d responses to %0d requests across eight capacity settings and",
		         n_checked, n_sent);
		$display("four idling patterns; %0d inserts refused when full, %0d entries located.",
		         n_refused, n_located);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
